### rtl/utf8_stream_decoder_assert.svh
// assertion macros for the utf8 stream decoder
// included by the top level; empty bodies when SYNTH is defined
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define UTF8D_ASSERT_HOLDS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("utf8d assertion failed");
// condition must never be true outside reset
`define UTF8D_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("utf8d forbidden condition seen");
`else
`define UTF8D_ASSERT_HOLDS(lbl, clk, rstn, prop)
`define UTF8D_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/utf8d_pkg.sv
// shared types and constants of the utf8 stream decoder
// no dependencies
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned PendW  = 2;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // byte class upper bounds
  localparam logic [ByteW-1:0] AsciiMax = 8'h7F;
  localparam logic [ByteW-1:0] ContMax  = 8'hBF;
  localparam logic [ByteW-1:0] Lead2Max = 8'hDF;
  localparam logic [ByteW-1:0] Lead3Max = 8'hEF;
  localparam logic [ByteW-1:0] Lead4Max = 8'hF7;

  localparam logic [CpW-1:0] ReplChar = 21'h00FFFD;

  typedef struct packed {
    logic [ByteW-1:0] byte_in;
    logic             end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           replaced;
    logic           run_last;
  } out_item_t;

  // one byte's results: an optional replacement ahead of a main result
  typedef struct packed {
    logic           has_pre;
    logic [CpW-1:0] code_point;
    logic           replaced;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/utf8d_front.sv
// front part: accepts bytes, tracks the pending sequence, forms result bundles
// depends on utf8d_pkg
module utf8d_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  utf8d_pkg::in_item_t  in_item_i,
  input  utf8d_pkg::q_status_t q_status_i,
  output logic                 in_ready_o,
  output logic                 push_o,
  output utf8d_pkg::q_entry_t  entry_o
);

  logic [utf8d_pkg::PendW-1:0] pend_q, pend_d;
  logic [utf8d_pkg::CpW-1:0]   acc_q, acc_d;
  logic                        main_v;
  logic                        accept;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    pend_d           = pend_q;
    acc_d            = acc_q;
    main_v           = 1'b0;
    entry_o.has_pre  = 1'b0;
    entry_o.code_point = '0;
    entry_o.replaced = 1'b0;
    priority if (in_item_i.byte_in <= utf8d_pkg::AsciiMax) begin
      entry_o.has_pre    = (pend_q != '0);
      pend_d             = '0;
      main_v             = 1'b1;
      entry_o.code_point = utf8d_pkg::CpW'(in_item_i.byte_in);
    end else if (in_item_i.byte_in <= utf8d_pkg::ContMax) begin
      if (pend_q != '0) begin
        acc_d  = {acc_q[utf8d_pkg::CpW-7:0], in_item_i.byte_in[5:0]};
        pend_d = pend_q - utf8d_pkg::PendW'(1);
        if (pend_d == '0) begin
          main_v             = 1'b1;
          entry_o.code_point = acc_d;
        end
      end else begin
        // stray continuation
        main_v             = 1'b1;
        entry_o.code_point = utf8d_pkg::ReplChar;
        entry_o.replaced   = 1'b1;
      end
    end else if (in_item_i.byte_in <= utf8d_pkg::Lead2Max) begin
      pend_d = utf8d_pkg::PendW'(1);
      acc_d  = utf8d_pkg::CpW'(in_item_i.byte_in[4:0]);
    end else if (in_item_i.byte_in <= utf8d_pkg::Lead3Max) begin
      pend_d = utf8d_pkg::PendW'(2);
      acc_d  = utf8d_pkg::CpW'(in_item_i.byte_in[3:0]);
    end else if (in_item_i.byte_in <= utf8d_pkg::Lead4Max) begin
      pend_d = utf8d_pkg::PendW'(3);
      acc_d  = utf8d_pkg::CpW'(in_item_i.byte_in[2:0]);
    end else begin
      main_v             = 1'b1;
      entry_o.code_point = utf8d_pkg::ReplChar;
      entry_o.replaced   = 1'b1;
      pend_d             = '0;
    end
    if (in_item_i.end_of_string) begin
      // unfinished sequence at string end; never coincides with another result
      if (pend_d != '0) begin
        main_v             = 1'b1;
        entry_o.code_point = utf8d_pkg::ReplChar;
        entry_o.replaced   = 1'b1;
      end
      pend_d = '0;
      acc_d  = '0;
    end
  end

  assign push_o = accept && main_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

endmodule

### rtl/utf8d_queue.sv
// two-entry queue of result bundles between front and back
// depends on utf8d_pkg
module utf8d_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  utf8d_pkg::q_entry_t  entry_i,
  input  logic                 pop_i,
  output utf8d_pkg::q_entry_t  head_o,
  output utf8d_pkg::q_status_t status_o
);

  utf8d_pkg::q_entry_t          mem_q [utf8d_pkg::QDepth];
  logic [utf8d_pkg::QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [utf8d_pkg::QCntW-1:0]  cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == utf8d_pkg::QCntW'(utf8d_pkg::QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + utf8d_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - utf8d_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + utf8d_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + utf8d_pkg::QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### rtl/utf8d_back.sv
// back part: unpacks bundles into single results in an output register
// depends on utf8d_pkg
module utf8d_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  utf8d_pkg::q_entry_t  head_i,
  input  utf8d_pkg::q_status_t q_status_i,
  input  logic                 out_ready_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  output utf8d_pkg::out_item_t out_item_o
);

  logic                 valid_q, valid_d;
  logic                 phase_q, phase_d;
  logic                 load;
  utf8d_pkg::out_item_t out_q, out_d;

  assign load = (!valid_q || out_ready_i) && !q_status_i.empty;

  always_comb begin
    valid_d = valid_q && !out_ready_i;
    phase_d = phase_q;
    out_d   = out_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = 1'b1;
      if (head_i.has_pre && !phase_q) begin
        // replacement for the cut sequence goes first
        out_d.code_point = utf8d_pkg::ReplChar;
        out_d.replaced   = 1'b1;
        out_d.run_last   = 1'b0;
        phase_d          = 1'b1;
      end else begin
        out_d.code_point = head_i.code_point;
        out_d.replaced   = head_i.replaced;
        out_d.run_last   = 1'b1;
        phase_d          = 1'b0;
        pop_o            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/utf8_stream_decoder.sv
// channel  direction  payload                              handshake
// in       input      byte_in, end_of_string               in_valid_i / in_ready_o
// out      output     code_point, replaced, run_last       out_valid_o / out_ready_i
//
// one byte accepted per cycle while the queue has room; results are queued, then registered
// a byte with two results (replacement then ascii) is popped once both are registered
// the output register sets the rate: one result per cycle while out_ready_i is high
// reset clears the pending count, accumulator, queue and output valid at once
// a stalled output fills the two-entry queue, then in_ready_o drops
`include "utf8_stream_decoder_assert.svh"
module utf8_stream_decoder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  utf8d_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output utf8d_pkg::out_item_t out_item_o
);

  // front to queue
  logic                 push;
  utf8d_pkg::q_entry_t  entry;
  // queue to back
  logic                 pop;
  utf8d_pkg::q_entry_t  head;
  utf8d_pkg::q_status_t q_status;

  // front: byte classification and sequence tracking
  utf8d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .in_ready_o (in_ready_o),
    .push_o     (push),
    .entry_o    (entry)
  );

  // decoupling queue, one bundle per byte that has results
  utf8d_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  // back: one queued result per cycle into the output register while out_ready_i is high
  utf8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .out_ready_i (out_ready_i),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  // queue must never overflow or underflow
  `UTF8D_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push && q_status.full && !pop)
  `UTF8D_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop && q_status.empty)
  // replaced results always carry the replacement character
  `UTF8D_ASSERT_HOLDS(a_repl_value, clk_i, rst_ni,
    (out_valid_o && out_item_o.replaced) |-> (out_item_o.code_point == utf8d_pkg::ReplChar))
  // a leading result of a byte is always the replacement for a cut sequence
  `UTF8D_ASSERT_HOLDS(a_pre_is_repl, clk_i, rst_ni,
    (out_valid_o && !out_item_o.run_last) |-> out_item_o.replaced)

endmodule
